// ----- src/linker_script_tokenizer_assert.svh -----
// Assertion macros shared by the checker of the linker script tokenizer.
`ifndef LINKER_SCRIPT_TOKENIZER_ASSERT_SVH
`define LINKER_SCRIPT_TOKENIZER_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle while arst_n is low.
`define LST_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// Next-cycle implication, sampled on clk and idle while arst_n is low.
`define LST_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

// ----- src/lst_pkg.sv -----
// Shared types and constants of the linker script tokenizer.
package lst_pkg;

	localparam int MAX_KW_LEN_DEF = 8;
	localparam int MAX_RES        = 5;
	localparam int NUM_KW         = 14;

	// Token kinds.
	localparam logic [3:0] TK_COMMA    = 4'd0;
	localparam logic [3:0] TK_NEWLINE  = 4'd1;
	localparam logic [3:0] TK_NUMBER   = 4'd2;
	localparam logic [3:0] TK_STR_CHAR = 4'd3;
	localparam logic [3:0] TK_STR_END  = 4'd4;
	localparam logic [3:0] TK_SECTION  = 4'd5;
	localparam logic [3:0] TK_ORG      = 4'd6;
	localparam logic [3:0] TK_EOF      = 4'd12;
	localparam logic [3:0] TK_DIAG     = 4'd13;

	// Diagnostic codes.
	localparam logic [2:0] DG_DOUBLE_SEP = 3'd0;
	localparam logic [2:0] DG_TOO_LARGE  = 3'd1;
	localparam logic [2:0] DG_NO_DIGITS  = 3'd2;
	localparam logic [2:0] DG_TRAIL_SEP  = 3'd3;
	localparam logic [2:0] DG_UNTERM_STR = 3'd4;
	localparam logic [2:0] DG_BAD_ESCAPE = 3'd5;
	localparam logic [2:0] DG_UNKNOWN_KW = 3'd6;
	localparam logic [2:0] DG_UNEXPECTED = 3'd7;
	localparam logic [2:0] DG_NONE       = 3'd0;

	// Keyword names, right-aligned string literals, with their lengths.
	localparam logic [63:0] KW_NAME [NUM_KW] = '{
		64'("WRAM0"), 64'("VRAM"), 64'("ROMX"), 64'("ROM0"), 64'("HRAM"),
		64'("WRAMX"), 64'("SRAM"), 64'("OAM"), 64'("ORG"), 64'("FLOATING"),
		64'("INCLUDE"), 64'("ALIGN"), 64'("DS"), 64'("OPTIONAL")
	};
	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd3, 4'd3, 4'd8,
		4'd7, 4'd5, 4'd2, 4'd8
	};

	typedef struct packed {
		logic [3:0]  kind;
		logic [31:0] value;
		logic [2:0]  diag;
	} token_t;

	// All tokens caused by one input item.
	typedef struct packed {
		token_t [MAX_RES-1:0] tok;
		logic [2:0]           cnt;
	} bundle_t;

	// Status of the queue towards its neighbours.
	typedef struct packed {
		logic can_push;
		logic not_empty;
	} q_stat_t;

	// Appends one token to a bundle.
	function automatic bundle_t emit(bundle_t b, logic [3:0] k, logic [31:0] v,
		logic [2:0] d);
		bundle_t r;
		r = b;
		if (r.cnt < 3'(MAX_RES)) begin
			r.tok[r.cnt] = '{kind: k, value: v, diag: d};
			r.cnt = r.cnt + 3'd1;
		end
		return r;
	endfunction

endpackage

// ----- src/lst_if.sv -----
// Stream interfaces of the tokenizer: script bytes in, tokens out.
interface lst_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;
	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface lst_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [31:0] token_value;
	logic [2:0]  diag_code;
	logic        last_of_run;
	modport source (output valid, output token_kind, output token_value,
		output diag_code, output last_of_run, input ready);
	modport sink (input valid, input token_kind, input token_value,
		input diag_code, input last_of_run, output ready);
endinterface

// ----- src/lst_front.sv -----
// Lexer front end: classifies each byte and builds the tokens it causes.
module lst_front import lst_pkg::*; #(
	parameter int MAX_KEYWORD_LEN = MAX_KW_LEN_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	lst_in_if.sink       text_in,
	input  q_stat_t      q_stat,
	output logic         push,
	output bundle_t      push_data
);

	localparam int IW  = $clog2(MAX_KEYWORD_LEN);
	localparam int KLW = $clog2(MAX_KEYWORD_LEN + 2);

	typedef enum logic [8:0] {
		M_IDLE     = 9'b000000001,
		M_COMMENT  = 9'b000000010,
		M_SKIPLINE = 9'b000000100,
		M_ZERO     = 9'b000001000,
		M_NUMBER   = 9'b000010000,
		M_DISCARD  = 9'b000100000,
		M_STRING   = 9'b001000000,
		M_ESCAPE   = 9'b010000000,
		M_KEYWORD  = 9'b100000000
	} mode_t;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;

	// Radix codes.
	localparam logic [1:0] RX_DEC = 2'd0;
	localparam logic [1:0] RX_HEX = 2'd1;
	localparam logic [1:0] RX_OCT = 2'd2;
	localparam logic [1:0] RX_BIN = 2'd3;

	mode_t          mode_q, nx_mode;
	logic [31:0]    acc_q, nx_acc;
	logic [1:0]     radix_q, nx_radix;
	logic           seen_q, nx_seen;
	logic           sep_q, nx_sep;
	logic [KLW-1:0] klen_q, nx_klen;
	logic           prev_cr_q, nx_prev;
	logic [7:0]     kw_q [MAX_KEYWORD_LEN];

	logic           accept;
	logic [7:0]     c;
	logic           is_nl, is_letter, is_dec;
	logic [7:0]     c_upper;
	logic [1:0]     num_radix;
	logic [31:0]    num_acc;
	logic [4:0]     dval;
	logic           dig_ok;
	logic [35:0]    mac;
	logic           ovf;
	logic           kw_hit;
	logic [3:0]     kw_kind;
	logic [31:0]    kw_value;
	logic           kw_we;
	logic [IW-1:0]  kw_idx;
	logic           do_num, do_idle;
	logic [7:0]     esc_c;
	bundle_t        b;

	assign accept        = text_in.valid && text_in.ready;
	assign text_in.ready = q_stat.can_push;
	assign c             = text_in.text_byte;
	assign is_nl         = (c == CH_CR) || (c == CH_LF);
	assign is_dec        = (c >= "0") && (c <= "9");
	assign is_letter     = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
	assign c_upper       = ((c >= "a") && (c <= "z")) ? (c - 8'd32) : c;

	// A number that leaves the zero prefix starts as decimal zero.
	assign num_radix = (mode_q == M_ZERO) ? RX_DEC : radix_q;
	assign num_acc   = (mode_q == M_ZERO) ? 32'd0 : acc_q;

	// Digit value of the byte and its check against the radix.
	always_comb begin
		dval = 5'd31;
		if (is_dec) begin
			dval = 5'(c - "0");
		end else if ((c >= "a") && (c <= "f")) begin
			dval = 5'(c - "a") + 5'd10;
		end else if ((c >= "A") && (c <= "F")) begin
			dval = 5'(c - "A") + 5'd10;
		end
		case (num_radix)
			RX_DEC:  dig_ok = dval < 5'd10;
			RX_HEX:  dig_ok = dval < 5'd16;
			RX_OCT:  dig_ok = dval < 5'd8;
			default: dig_ok = dval < 5'd2;
		endcase
	end

	// Shift-add of the accumulator; any bit from bit 32 upwards is an overflow.
	always_comb begin
		case (num_radix)
			RX_DEC:  mac = {num_acc, 3'b000} + {3'b000, num_acc, 1'b0};
			RX_HEX:  mac = {num_acc, 4'b0000};
			RX_OCT:  mac = {1'b0, num_acc, 3'b000};
			default: mac = {3'b000, num_acc, 1'b0};
		endcase
		mac = mac + {32'd0, dval[3:0]};
		ovf = mac[35:32] != 4'd0;
	end

	// Keyword lookup over the fourteen names, each compared independently.
	always_comb begin
		logic       ok;
		logic [2:0] pos;
		kw_hit   = 1'b0;
		kw_kind  = TK_DIAG;
		kw_value = 32'd0;
		for (int i = 0; i < NUM_KW; i++) begin
			ok = klen_q == KLW'(KW_LEN[i]);
			for (int j = 0; j < 8; j++) begin
				pos = 3'(KW_LEN[i] - 4'd1 - 4'(j));
				if ((4'(j) < KW_LEN[i]) && (kw_q[j] != KW_NAME[i][8*pos +: 8])) begin
					ok = 1'b0;
				end
			end
			if (ok && !kw_hit) begin
				kw_hit = 1'b1;
				if (i < 8) begin
					kw_kind  = TK_SECTION;
					kw_value = 32'(i);
				end else begin
					kw_kind  = TK_ORG + 4'(i - 8);
				end
			end
		end
	end

	// Escape translation inside strings.
	always_comb begin
		case (c)
			"n":     esc_c = CH_LF;
			"r":     esc_c = CH_CR;
			"t":     esc_c = CH_TAB;
			"0":     esc_c = 8'd0;
			default: esc_c = c;
		endcase
	end

	// Mode step, number step and idle step, in that order.
	always_comb begin
		nx_mode  = mode_q;
		nx_acc   = acc_q;
		nx_radix = radix_q;
		nx_seen  = seen_q;
		nx_sep   = sep_q;
		nx_klen  = klen_q;
		nx_prev  = 1'b0;
		b        = '0;
		do_num   = 1'b0;
		do_idle  = 1'b0;
		kw_we    = 1'b0;
		kw_idx   = klen_q[IW-1:0];
		if (text_in.end_of_text) begin
			case (mode_q)
				M_ZERO:   b = emit(b, TK_NUMBER, 32'd0, DG_NONE);
				M_NUMBER: begin
					if (!seen_q) b = emit(b, TK_DIAG, 32'd0, DG_NO_DIGITS);
					if (sep_q) b = emit(b, TK_DIAG, 32'd0, DG_TRAIL_SEP);
					b = emit(b, TK_NUMBER, acc_q, DG_NONE);
				end
				M_STRING, M_ESCAPE: begin
					b = emit(b, TK_DIAG, 32'd0, DG_UNTERM_STR);
					b = emit(b, TK_STR_END, 32'd0, DG_NONE);
				end
				M_KEYWORD: begin
					if (kw_hit) b = emit(b, kw_kind, kw_value, DG_NONE);
					else b = emit(b, TK_DIAG, 32'd0, DG_UNKNOWN_KW);
				end
				default: ;
			endcase
			b        = emit(b, TK_NEWLINE, 32'd0, DG_NONE);
			b        = emit(b, TK_EOF, 32'd0, DG_NONE);
			nx_mode  = M_IDLE;
			nx_acc   = 32'd0;
			nx_radix = RX_DEC;
			nx_seen  = 1'b0;
			nx_sep   = 1'b0;
			nx_klen  = '0;
		end else begin
			case (mode_q)
				M_COMMENT, M_SKIPLINE: do_idle = is_nl;
				M_ZERO: begin
					nx_mode = M_NUMBER;
					nx_acc  = 32'd0;
					nx_sep  = 1'b0;
					nx_seen = 1'b0;
					if ((c == "x") || (c == "X")) begin
						nx_radix = RX_HEX;
					end else if ((c == "o") || (c == "O")) begin
						nx_radix = RX_OCT;
					end else if ((c == "b") || (c == "B")) begin
						nx_radix = RX_BIN;
					end else begin
						nx_radix = RX_DEC;
						nx_seen  = 1'b1;
						do_num   = 1'b1;
					end
				end
				M_NUMBER:  do_num = 1'b1;
				M_DISCARD: do_idle = (c != "_") && !dig_ok;
				M_STRING: begin
					if (is_nl) begin
						b       = emit(b, TK_DIAG, 32'd0, DG_UNTERM_STR);
						b       = emit(b, TK_STR_END, 32'd0, DG_NONE);
						do_idle = 1'b1;
					end else if (c == "\"") begin
						b       = emit(b, TK_STR_END, 32'd0, DG_NONE);
						nx_mode = M_IDLE;
					end else if (c == "\\") begin
						nx_mode = M_ESCAPE;
					end else begin
						b = emit(b, TK_STR_CHAR, 32'(c), DG_NONE);
					end
				end
				M_ESCAPE: begin
					if (is_nl) begin
						b       = emit(b, TK_DIAG, 32'd0, DG_UNTERM_STR);
						b       = emit(b, TK_STR_END, 32'd0, DG_NONE);
						do_idle = 1'b1;
					end else begin
						nx_mode = M_STRING;
						if ((c != "n") && (c != "r") && (c != "t") && (c != "0") &&
							(c != "\\") && (c != "\"") && (c != "'")) begin
							b = emit(b, TK_DIAG, 32'(c), DG_BAD_ESCAPE);
						end
						b = emit(b, TK_STR_CHAR, 32'(esc_c), DG_NONE);
					end
				end
				M_KEYWORD: begin
					if (is_letter || is_dec) begin
						kw_we = klen_q < KLW'(MAX_KEYWORD_LEN);
						if (klen_q <= KLW'(MAX_KEYWORD_LEN)) nx_klen = klen_q + 1'b1;
					end else begin
						if (kw_hit) b = emit(b, kw_kind, kw_value, DG_NONE);
						else b = emit(b, TK_DIAG, 32'd0, DG_UNKNOWN_KW);
						do_idle = 1'b1;
					end
				end
				default: begin
					nx_mode = M_IDLE;
					do_idle = !(prev_cr_q && (c == CH_LF));
				end
			endcase

			// Digit, separator or end of a number.
			if (do_num) begin
				if (c == "_") begin
					if (nx_sep) b = emit(b, TK_DIAG, 32'd0, DG_DOUBLE_SEP);
					nx_sep = 1'b1;
				end else if (!dig_ok) begin
					if (!nx_seen) b = emit(b, TK_DIAG, 32'd0, DG_NO_DIGITS);
					if (nx_sep) b = emit(b, TK_DIAG, 32'd0, DG_TRAIL_SEP);
					b       = emit(b, TK_NUMBER, nx_acc, DG_NONE);
					do_idle = 1'b1;
				end else if (ovf) begin
					b       = emit(b, TK_DIAG, 32'd0, DG_TOO_LARGE);
					b       = emit(b, TK_NUMBER, 32'd0, DG_NONE);
					nx_mode = M_DISCARD;
				end else begin
					nx_acc  = mac[31:0];
					nx_seen = 1'b1;
					nx_sep  = 1'b0;
				end
			end

			// Byte seen between tokens.
			if (do_idle) begin
				nx_mode = M_IDLE;
				if ((c == CH_SPACE) || (c == CH_TAB)) begin
					nx_mode = M_IDLE;
				end else if (c == ";") begin
					nx_mode = M_COMMENT;
				end else if (c == ",") begin
					b = emit(b, TK_COMMA, 32'd0, DG_NONE);
				end else if (is_nl) begin
					b       = emit(b, TK_NEWLINE, 32'd0, DG_NONE);
					nx_prev = c == CH_CR;
				end else if (c == "\"") begin
					nx_mode = M_STRING;
				end else if ((c == "$") || (c == "%") || (c == "&")) begin
					nx_mode  = M_NUMBER;
					nx_radix = (c == "$") ? RX_HEX : ((c == "%") ? RX_BIN : RX_OCT);
					nx_acc   = 32'd0;
					nx_seen  = 1'b0;
					nx_sep   = 1'b0;
				end else if (c == "0") begin
					nx_mode = M_ZERO;
				end else if (is_dec) begin
					nx_mode  = M_NUMBER;
					nx_radix = RX_DEC;
					nx_acc   = 32'(c - "0");
					nx_seen  = 1'b1;
					nx_sep   = 1'b0;
				end else if (is_letter) begin
					nx_mode = M_KEYWORD;
					kw_we   = 1'b1;
					kw_idx  = '0;
					nx_klen = KLW'(1);
				end else begin
					b       = emit(b, TK_DIAG, 32'(c), DG_UNEXPECTED);
					nx_mode = M_SKIPLINE;
				end
			end
		end
	end

	assign push      = accept && (b.cnt != 3'd0);
	assign push_data = b;

	// Lexer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= M_IDLE;
			acc_q     <= 32'd0;
			radix_q   <= RX_DEC;
			seen_q    <= 1'b0;
			sep_q     <= 1'b0;
			klen_q    <= '0;
			prev_cr_q <= 1'b0;
		end else if (accept) begin
			mode_q    <= nx_mode;
			acc_q     <= nx_acc;
			radix_q   <= nx_radix;
			seen_q    <= nx_seen;
			sep_q     <= nx_sep;
			klen_q    <= nx_klen;
			prev_cr_q <= nx_prev;
		end
	end

	// Keyword characters, upper case.
	always_ff @(posedge clk) begin
		if (accept && kw_we) begin
			kw_q[kw_idx] <= c_upper;
		end
	end

endmodule

// ----- src/lst_queue.sv -----
// Two-entry queue of token bundles between the lexer and the serialiser.
module lst_queue import lst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  bundle_t push_data,
	input  logic    pop,
	output bundle_t head,
	output q_stat_t q_stat
);

	bundle_t    mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign head             = mem_q[rd_q];
	assign q_stat.not_empty = count_q != 2'd0;
	assign q_stat.can_push  = (count_q != 2'd2) || pop;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= !wr_q;
			if (pop) rd_q <= !rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- src/lst_back.sv -----
// Serialiser: sends the tokens of the head bundle one transfer at a time.
module lst_back import lst_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  bundle_t head,
	input  q_stat_t q_stat,
	output logic    pop,
	lst_out_if.source token_out
);

	logic [2:0] idx_q;
	logic       last;
	token_t     cur;

	assign cur   = head.tok[idx_q];
	assign last  = idx_q == (head.cnt - 3'd1);
	assign pop   = token_out.valid && token_out.ready && last;

	assign token_out.valid       = q_stat.not_empty;
	assign token_out.token_kind  = cur.kind;
	assign token_out.token_value = cur.value;
	assign token_out.diag_code   = cur.diag;
	assign token_out.last_of_run = last;

	// Position within the head bundle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
		end else if (token_out.valid && token_out.ready) begin
			idx_q <= last ? 3'd0 : idx_q + 3'd1;
		end
	end

endmodule

// ----- src/linker_script_tokenizer.sv -----
// Linker script tokenizer: one script byte in, zero to five tokens out.
// The tokens of a byte are registered in the bundle queue before they are offered.
// Throughput: one byte per cycle while each byte yields at most one token and
// token_out is ready; a byte with more tokens holds the single output port until
// all are sent, and the two-entry bundle queue sets how far the lexer may run ahead.
// Reset: arst_n clears lexer state and empties the queue at once.
module linker_script_tokenizer import lst_pkg::*; #(
	parameter int MAX_KEYWORD_LEN = MAX_KW_LEN_DEF
) (
	input logic       clk,
	input logic       arst_n,
	lst_in_if.sink    text_in,
	lst_out_if.source token_out
);

	logic    push, pop;
	bundle_t push_data, head;
	q_stat_t q_stat;

	lst_front #(.MAX_KEYWORD_LEN(MAX_KEYWORD_LEN)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_in   (text_in),
		.q_stat    (q_stat),
		.push      (push),
		.push_data (push_data)
	);

	lst_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	lst_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.token_out (token_out)
	);

endmodule

// ----- src/lst_checker.sv -----
// Port checker of the tokenizer and its bind to the top level.
`include "linker_script_tokenizer_assert.svh"

module lst_checker import lst_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [3:0]  token_kind,
	input logic [31:0] token_value,
	input logic [2:0]  diag_code,
	input logic        last_of_run
);

	// A stalled token stays offered and unchanged.
	`LST_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_value) && $stable(diag_code) && $stable(last_of_run))

	// End of file always closes the run of its byte.
	`LST_ASSERT_IMP(a_eof_last, out_valid && (token_kind == TK_EOF), last_of_run)

	// Only diagnostics carry a diagnostic code.
	`LST_ASSERT_IMP(a_diag_only, out_valid && (token_kind != TK_DIAG), diag_code == DG_NONE)

	// No kind beyond the diagnostic code is ever produced.
	`LST_ASSERT_IMP(a_kind_range, out_valid, token_kind <= TK_DIAG)

endmodule

bind linker_script_tokenizer lst_checker u_lst_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (token_out.valid),
	.out_ready   (token_out.ready),
	.token_kind  (token_out.token_kind),
	.token_value (token_out.token_value),
	.diag_code   (token_out.diag_code),
	.last_of_run (token_out.last_of_run)
);

// ----- tb/linker_script_tokenizer_tb.sv -----
// Self-checking testbench of the linker script tokenizer, with its own lexer model.
module linker_script_tokenizer_tb;
	import lst_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int KW_MAX      = MAX_KW_LEN_DEF;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_ITEMS  = 40;
	localparam int LONG_HOLD   = 80;

	typedef enum logic [3:0] {
		LX_IDLE, LX_COMMENT, LX_SKIPLINE, LX_ZERO, LX_NUMBER, LX_DISCARD,
		LX_STRING, LX_ESCAPE, LX_KEYWORD
	} lex_mode_t;

	typedef enum logic [1:0] {RX_DEC, RX_HEX, RX_OCT, RX_BIN} radix_t;

	typedef struct {
		logic [7:0] ch;
		logic       eot;
		logic       drain_first;
	} text_item_t;

	typedef struct {
		logic [3:0]  kind;
		logic [31:0] value;
		logic [2:0]  diag;
		logic        last;
	} token_exp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lst_in_if  text_ch();
	lst_out_if tok_ch();

	linker_script_tokenizer u_dut (
		.clk(clk), .arst_n(arst_n), .text_in(text_ch), .token_out(tok_ch)
	);

	always #1 clk = ~clk;

	// Lexer state of the model.
	lex_mode_t   m_mode;
	logic [31:0] m_acc;
	radix_t      m_radix;
	logic        m_digits, m_sep, m_prev_cr;
	logic [7:0]  m_kw [KW_MAX];
	logic [3:0]  m_kwlen;

	text_item_t  pending_text [$];
	token_exp_t  expected_tokens [$];
	token_exp_t  byte_tokens [$];
	int          cycles = 0, errors = 0, bytes_sent = 0, tokens_seen = 0, total_items = 0;
	bit          tail = 0;

	function automatic logic [31:0] base_of(radix_t r);
		case (r)
			RX_HEX:  return 32'd16;
			RX_OCT:  return 32'd8;
			RX_BIN:  return 32'd2;
			default: return 32'd10;
		endcase
	endfunction

	function automatic int digit_val(logic [7:0] c, radix_t r);
		int v;
		v = -1;
		if (c >= "0" && c <= "9") v = c - "0";
		else if (c >= "a" && c <= "f") v = c - "a" + 10;
		else if (c >= "A" && c <= "F") v = c - "A" + 10;
		if (v < 0 || v >= int'(base_of(r))) return -1;
		return v;
	endfunction

	function automatic bit is_nl(logic [7:0] c);
		return c == 8'h0d || c == 8'h0a;
	endfunction

	function automatic bit is_alpha(logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	// Appends one token for the current byte, capped at the bundle size.
	task automatic put_token(logic [3:0] k, logic [31:0] v, logic [2:0] d);
		token_exp_t t;
		t = '{kind: k, value: v, diag: d, last: 1'b0};
		if (byte_tokens.size() < MAX_RES) byte_tokens.insert(byte_tokens.size(), t);
	endtask

	task automatic clear_lexer();
		m_mode = LX_IDLE;
		m_acc = '0;
		m_radix = RX_DEC;
		m_digits = 0;
		m_sep = 0;
		m_kwlen = '0;
		m_prev_cr = 0;
		foreach (m_kw[i]) m_kw[i] = '0;
	endtask

	task automatic begin_number(radix_t r, logic [31:0] v, logic seen);
		m_mode = LX_NUMBER;
		m_radix = r;
		m_acc = v;
		m_digits = seen;
		m_sep = 0;
	endtask

	task automatic close_number();
		if (!m_digits) put_token(TK_DIAG, '0, DG_NO_DIGITS);
		if (m_sep) put_token(TK_DIAG, '0, DG_TRAIL_SEP);
		put_token(TK_NUMBER, m_acc, DG_NONE);
		m_mode = LX_IDLE;
	endtask

	// Matches the collected word against the keyword table.
	task automatic close_keyword();
		bit hit;
		int len;
		m_mode = LX_IDLE;
		if (m_kwlen <= KW_MAX) begin
			for (int i = 0; i < NUM_KW; i++) begin
				len = KW_LEN[i];
				if (len != m_kwlen) continue;
				hit = 1;
				for (int j = 0; j < len; j++)
					if (m_kw[j] != KW_NAME[i][8*(len-1-j) +: 8]) hit = 0;
				if (hit) begin
					if (i < 8) put_token(TK_SECTION, 32'(i), DG_NONE);
					else put_token(TK_ORG + 4'(i - 8), '0, DG_NONE);
					return;
				end
			end
		end
		put_token(TK_DIAG, '0, DG_UNKNOWN_KW);
	endtask

	task automatic push_kw_char(logic [7:0] c);
		if (c >= "a" && c <= "z") c = c - 8'd32;
		if (m_kwlen < KW_MAX) m_kw[m_kwlen] = c;
		if (m_kwlen <= KW_MAX) m_kwlen = m_kwlen + 4'd1;
	endtask

	// A byte seen between tokens.
	task automatic start_token(logic [7:0] c);
		m_mode = LX_IDLE;
		if (c == " " || c == 8'h09) return;
		if (c == ";") m_mode = LX_COMMENT;
		else if (c == ",") put_token(TK_COMMA, '0, DG_NONE);
		else if (is_nl(c)) begin
			put_token(TK_NEWLINE, '0, DG_NONE);
			m_prev_cr = (c == 8'h0d);
		end else if (c == "\"") m_mode = LX_STRING;
		else if (c == "$") begin_number(RX_HEX, '0, 0);
		else if (c == "%") begin_number(RX_BIN, '0, 0);
		else if (c == "&") begin_number(RX_OCT, '0, 0);
		else if (c == "0") m_mode = LX_ZERO;
		else if (c >= "1" && c <= "9") begin_number(RX_DEC, 32'(c - "0"), 1);
		else if (is_alpha(c)) begin
			m_mode = LX_KEYWORD;
			m_kwlen = '0;
			push_kw_char(c);
		end else begin
			put_token(TK_DIAG, 32'(c), DG_UNEXPECTED);
			m_mode = LX_SKIPLINE;
		end
	endtask

	task automatic number_char(logic [7:0] c);
		int d;
		logic [31:0] b;
		b = base_of(m_radix);
		if (c == "_") begin
			if (m_sep) put_token(TK_DIAG, '0, DG_DOUBLE_SEP);
			m_sep = 1;
			return;
		end
		d = digit_val(c, m_radix);
		if (d < 0) begin
			close_number();
			start_token(c);
			return;
		end
		if (m_acc > (32'hFFFF_FFFF - 32'(d)) / b) begin
			put_token(TK_DIAG, '0, DG_TOO_LARGE);
			put_token(TK_NUMBER, '0, DG_NONE);
			m_mode = LX_DISCARD;
			return;
		end
		m_acc = m_acc * b + 32'(d);
		m_digits = 1;
		m_sep = 0;
	endtask

	// Computes the tokens of one transferred item and queues them.
	task automatic lex_item(logic [7:0] c, logic eot);
		logic       was_cr;
		logic [7:0] e;
		was_cr = m_prev_cr;
		m_prev_cr = 0;
		byte_tokens.delete();
		if (eot) begin
			case (m_mode)
				LX_ZERO:    put_token(TK_NUMBER, '0, DG_NONE);
				LX_NUMBER:  close_number();
				LX_STRING, LX_ESCAPE: begin
					put_token(TK_DIAG, '0, DG_UNTERM_STR);
					put_token(TK_STR_END, '0, DG_NONE);
				end
				LX_KEYWORD: close_keyword();
				default: ;
			endcase
			put_token(TK_NEWLINE, '0, DG_NONE);
			put_token(TK_EOF, '0, DG_NONE);
			clear_lexer();
		end else begin
			case (m_mode)
				LX_COMMENT, LX_SKIPLINE: if (is_nl(c)) start_token(c);
				LX_ZERO: begin
					if (c == "x" || c == "X") begin_number(RX_HEX, '0, 0);
					else if (c == "o" || c == "O") begin_number(RX_OCT, '0, 0);
					else if (c == "b" || c == "B") begin_number(RX_BIN, '0, 0);
					else begin
						begin_number(RX_DEC, '0, 1);
						number_char(c);
					end
				end
				LX_NUMBER: number_char(c);
				LX_DISCARD: if (c != "_" && digit_val(c, m_radix) < 0) start_token(c);
				LX_STRING: begin
					if (is_nl(c)) begin
						put_token(TK_DIAG, '0, DG_UNTERM_STR);
						put_token(TK_STR_END, '0, DG_NONE);
						start_token(c);
					end else if (c == "\"") begin
						put_token(TK_STR_END, '0, DG_NONE);
						m_mode = LX_IDLE;
					end else if (c == "\\") m_mode = LX_ESCAPE;
					else put_token(TK_STR_CHAR, 32'(c), DG_NONE);
				end
				LX_ESCAPE: begin
					if (is_nl(c)) begin
						put_token(TK_DIAG, '0, DG_UNTERM_STR);
						put_token(TK_STR_END, '0, DG_NONE);
						start_token(c);
					end else begin
						m_mode = LX_STRING;
						e = c;
						if (c == "n") e = 8'h0a;
						else if (c == "r") e = 8'h0d;
						else if (c == "t") e = 8'h09;
						else if (c == "0") e = 8'h00;
						else if (c != "\\" && c != "\"" && c != "'")
							put_token(TK_DIAG, 32'(c), DG_BAD_ESCAPE);
						put_token(TK_STR_CHAR, 32'(e), DG_NONE);
					end
				end
				LX_KEYWORD: begin
					if (is_alpha(c) || (c >= "0" && c <= "9")) push_kw_char(c);
					else begin
						close_keyword();
						start_token(c);
					end
				end
				default: begin
					m_mode = LX_IDLE;
					if (!(was_cr && c == 8'h0a)) start_token(c);
				end
			endcase
		end
		foreach (byte_tokens[i]) begin
			if (i == byte_tokens.size() - 1) byte_tokens[i].last = 1'b1;
			expected_tokens.insert(expected_tokens.size(), byte_tokens[i]);
		end
	endtask

	// Stimulus building blocks.
	task automatic add_byte(logic [7:0] c);
		pending_text.insert(pending_text.size(), '{ch: c, eot: 1'b0, drain_first: 1'b0});
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	task automatic add_end();
		pending_text.insert(pending_text.size(),
			'{ch: 8'($urandom), eot: 1'b1, drain_first: 1'b0});
	endtask

	task automatic add_digits(int n, string set);
		for (int i = 0; i < n; i++) begin
			add_byte(set[$urandom_range(0, set.len() - 1)]);
			if ($urandom_range(0, 9) == 0) add_byte("_");
		end
	endtask

	// One random fragment of script text, mostly well formed.
	task automatic add_fragment();
		string kw [14] = '{"WRAM0", "VRAM", "ROMX", "ROM0", "HRAM", "WRAMX", "SRAM",
			"OAM", "ORG", "FLOATING", "INCLUDE", "ALIGN", "DS", "OPTIONAL"};
		string w;
		logic [7:0] c;
		case ($urandom_range(0, 12))
			0: add_digits($urandom_range(1, 9), "0123456789");
			1: begin
				if ($urandom_range(0, 1)) add_byte("$");
				else add_text($urandom_range(0, 1) ? "0x" : "0X");
				add_digits($urandom_range(0, 8), "0123456789abcdefABCDEF");
			end
			2: begin
				if ($urandom_range(0, 1)) add_byte("%");
				else add_text($urandom_range(0, 1) ? "0b" : "0B");
				add_digits($urandom_range(0, 12), "01");
			end
			3: begin
				if ($urandom_range(0, 1)) add_byte("&");
				else add_text($urandom_range(0, 1) ? "0o" : "0O");
				add_digits($urandom_range(0, 11), "01234567");
			end
			4: begin
				add_byte("$");
				add_digits($urandom_range(9, 12), "0123456789abcdefABCDEF");
			end
			5: begin
				w = kw[$urandom_range(0, 13)];
				if ($urandom_range(0, 5) == 0) w = {w, "Q9ZZ"};
				for (int i = 0; i < w.len(); i++) begin
					c = w[i];
					if (is_alpha(c) && $urandom_range(0, 1)) c = c + 8'd32;
					add_byte(c);
				end
			end
			6: begin
				add_byte("\"");
				repeat ($urandom_range(0, 4)) begin
					if ($urandom_range(0, 3) == 0) begin
						add_byte("\\");
						w = "nrt0\\\"'qZ";
						add_byte(w[$urandom_range(0, w.len() - 1)]);
					end else add_byte(8'($urandom_range(32, 255)));
				end
				if ($urandom_range(0, 4) != 0) add_byte("\"");
			end
			7: begin
				add_byte(";");
				repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(32, 255)));
				add_byte(8'h0a);
			end
			8: add_byte($urandom_range(0, 1) ? "," : ($urandom_range(0, 1) ? " " : 8'h09));
			9: begin
				if ($urandom_range(0, 1)) add_byte(8'h0d);
				if ($urandom_range(0, 2)) add_byte(8'h0a);
				else add_byte(8'h0d);
			end
			10: begin
				add_byte(8'($urandom));
				add_byte(8'($urandom));
			end
			11: if ($urandom_range(0, 2) == 0) add_end();
			default: add_byte(" ");
		endcase
		// Usually a separator follows the fragment.
		case ($urandom_range(0, 3))
			0: add_byte(" ");
			1: add_byte(",");
			2: add_byte(8'h0a);
			default: ;
		endcase
	endtask

	// Sender: presents queued bytes at the falling edge, with random gaps.
	logic [7:0] cur_ch;
	logic       cur_eot;
	logic       in_taken = 1'b0;
	int         send_gap = 0;

	always @(posedge clk) begin
		in_taken = text_ch.valid && text_ch.ready;
		if (in_taken) begin
			lex_item(cur_ch, cur_eot);
			bytes_sent++;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (!text_ch.valid || in_taken)) begin
			in_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				text_ch.valid <= 1'b0;
			end else if (pending_text.size() > 0 &&
				(!pending_text[0].drain_first || expected_tokens.size() == 0)) begin
				text_ch.valid       <= 1'b1;
				text_ch.text_byte   <= pending_text[0].ch;
				text_ch.end_of_text <= pending_text[0].eot;
				cur_ch  = pending_text[0].ch;
				cur_eot = pending_text[0].eot;
				void'(pending_text.pop_front());
				if (pending_text.size() < TAIL_ITEMS) tail = 1;
				if (!tail && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 7);
			end else text_ch.valid <= 1'b0;
		end
	end

	// Receiver: random stall bursts, and one long hold-off.
	int  recv_gap = 0;
	int  long_hold = 0;
	bit  long_done = 0;

	always @(negedge clk) begin
		if (arst_n) begin
			if (!long_done && tokens_seen >= 60) begin
				long_done = 1;
				long_hold = LONG_HOLD;
			end
			if (long_hold > 0) begin
				long_hold--;
				tok_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				tok_ch.ready <= 1'b0;
			end else begin
				tok_ch.ready <= 1'b1;
				if (!tail && $urandom_range(0, 6) == 0) recv_gap = $urandom_range(1, 7);
			end
		end
	end

	// Token checker.
	token_exp_t want;

	always @(posedge clk) begin
		if (arst_n && tok_ch.valid && tok_ch.ready) begin
			tokens_seen++;
			if (expected_tokens.size() == 0) begin
				$error("unexpected token: kind %0d value %0h", tok_ch.token_kind,
					tok_ch.token_value);
				errors++;
			end else begin
				want = expected_tokens.pop_front();
				if (tok_ch.token_kind !== want.kind) begin
					$error("token_kind: expected %0d, got %0d", want.kind, tok_ch.token_kind);
					errors++;
				end
				if (tok_ch.token_value !== want.value) begin
					$error("token_value: expected %0h, got %0h", want.value,
						tok_ch.token_value);
					errors++;
				end
				if (tok_ch.diag_code !== want.diag) begin
					$error("diag_code: expected %0d, got %0d", want.diag, tok_ch.diag_code);
					errors++;
				end
				if (tok_ch.last_of_run !== want.last) begin
					$error("last_of_run: expected %0d, got %0d", want.last,
						tok_ch.last_of_run);
					errors++;
				end
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	initial begin
		text_ch.valid = 1'b0;
		text_ch.text_byte = '0;
		text_ch.end_of_text = 1'b0;
		tok_ch.ready = 1'b0;
		clear_lexer();

		// Directed: separators, overflow, prefixes, escapes, bad bytes, CR LF.
		add_text("$1__fFFFFFFFF_,0x;c");
		add_byte(8'h0d);
		add_byte(8'h0a);
		add_text("\"\\q\\");
		add_byte(8'h0a);
		add_byte(8'hff);
		add_byte(8'h80);
		add_byte(8'h0d);
		add_text("Dsx");
		add_end();
		pending_text[$].drain_first = 1'b1;
		total_items = pending_text.size();

		// Random well-formed fragments with some noise, ending on an end mark.
		while (pending_text.size() < total_items + 200) begin
			if (pending_text.size() == total_items + 100) begin
				add_fragment();
				pending_text[$].drain_first = 1'b1;
			end else add_fragment();
		end
		add_end();
		total_items = pending_text.size();

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_text.size() == 0 && bytes_sent == total_items);
		wait (expected_tokens.size() == 0);
		repeat (20) @(posedge clk);

		$display("Run covered %0d script bytes and end marks, %0d tokens checked.",
			bytes_sent, tokens_seen);
		$display("Numbers, keywords, strings, comments and error cases were mixed.");
		if (errors == 0 && expected_tokens.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
